[src/srpp_pkg.sv]
// Shared types, constants and sign-magnitude fixed-point helpers for the pair potential block.
`default_nettype none
package srpp_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int MAG_W         = 63;
  localparam int DIST_W        = 24;
  localparam int ALPHA_W       = 32;
  localparam int OUT_W         = 48;
  localparam int MUL_LAT       = 4;
  localparam int ADD_LAT       = 3;

  localparam logic [MAG_W-1:0] MAG_CAP     = {1'b1, {(MAG_W-1){1'b0}}};
  localparam logic [MAG_W-1:0] SCALE2_LIM  = (MAG_CAP - 63'd1) / 63'd2;
  localparam logic [MAG_W-1:0] SCALE3_LIM  = (MAG_CAP - 63'd1) / 63'd3;
  localparam logic [MAG_W-1:0] OUT_POS_MAX = 63'h0000_7FFF_FFFF_FFFF;
  localparam logic [MAG_W-1:0] OUT_NEG_MAX = 63'h0000_8000_0000_0000;

  typedef enum logic [0:0] {
    REG_CUTOFF = 1'b0,
    REG_SCALE  = 1'b1
  } reg_index_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BEYOND = 2'd1,
    ST_SAT    = 2'd2,
    ST_ZERO   = 2'd3
  } status_t;

  typedef struct packed {
    logic             neg;
    logic [MAG_W-1:0] mag;
  } fx_t;

  typedef struct packed {
    logic vld;
    logic zero;
    logic beyond;
  } flags_t;

  typedef struct packed {
    logic [OUT_W-1:0] energy;
    logic [OUT_W-1:0] force_res;
    status_t          status;
  } res_t;

  typedef struct packed {
    logic [OUT_W-1:0] val;
    logic             sat;
  } out_t;

  // Quotient width of the reciprocal: covers 2^(2F) plus half the largest distance.
  function automatic int div_width(input int f);
    return ((2 * f > DIST_W - 1) ? 2 * f : DIST_W - 1) + 1;
  endfunction

  function automatic fx_t fx_make(input logic neg, input logic [MAG_W:0] m);
    fx_t r;
    r.mag = (m >= {1'b0, MAG_CAP}) ? MAG_CAP : m[MAG_W-1:0];
    r.neg = (m == '0) ? 1'b0 : neg;
    return r;
  endfunction

  // A saturated operand wins, the first one if both are.
  function automatic fx_t fx_add(input fx_t a, input fx_t b);
    fx_t r;
    if (a.mag[MAG_W-1]) begin
      r = a;
    end else if (b.mag[MAG_W-1]) begin
      r = b;
    end else if (a.neg == b.neg) begin
      r = fx_make(a.neg, {1'b0, a.mag} + {1'b0, b.mag});
    end else if (a.mag >= b.mag) begin
      r = fx_make(a.neg, {1'b0, a.mag - b.mag});
    end else begin
      r = fx_make(b.neg, {1'b0, b.mag - a.mag});
    end
    return r;
  endfunction

  function automatic fx_t fx_scale(input fx_t a, input logic [1:0] k,
                                   input logic [MAG_W-1:0] lim);
    fx_t r;
    if (a.mag[MAG_W-1] || a.mag > lim) begin
      r = fx_make(a.neg, {1'b0, MAG_CAP});
    end else begin
      r = fx_make(a.neg, {1'b0, a.mag} * {{(MAG_W-1){1'b0}}, k});
    end
    return r;
  endfunction

  function automatic out_t fx_out(input fx_t v);
    out_t             r;
    logic [MAG_W-1:0] m;
    m     = v.mag;
    r.sat = 1'b0;
    if (v.neg) begin
      if (m > OUT_NEG_MAX) begin
        m     = OUT_NEG_MAX;
        r.sat = 1'b1;
      end
      r.val = ~m[OUT_W-1:0] + 48'd1;
    end else begin
      if (m > OUT_POS_MAX) begin
        m     = OUT_POS_MAX;
        r.sat = 1'b1;
      end
      r.val = m[OUT_W-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

[src/srpp_dly.sv]
// Enabled shift line that delays a word by a fixed number of pipeline stages.
`default_nettype none
module srpp_dly #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             en,
  input  wire logic [WIDTH-1:0] din,
  output logic      [WIDTH-1:0] dout
);

  logic [WIDTH-1:0] taps [DEPTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) taps[i] <= '0;
    end else if (en) begin
      taps[0] <= din;
      for (int i = 1; i < DEPTH; i++) taps[i] <= taps[i-1];
    end
  end

  assign dout = taps[DEPTH-1];

endmodule
`default_nettype wire

[src/srpp_div.sv]
// Pipelined restoring divider: rounded 2^(2F) / distance, one quotient bit per stage.
`default_nettype none
module srpp_div import srpp_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                en,
  input  wire logic [DIST_W-1:0]                   divisor,
  output logic      [div_width(FRAC_BITS)-1:0]     quot
);

  localparam int NW = div_width(FRAC_BITS);

  logic [NW-1:0]     num0;
  logic [DIST_W-1:0] rem_q [NW];
  logic [DIST_W-1:0] den_q [NW];
  logic [NW-1:0]     num_q [NW];
  logic [NW-1:0]     quo_q [NW];

  // Adding half the divisor makes the truncating division round to nearest.
  assign num0 = (NW'(1) << (2 * FRAC_BITS)) + NW'(divisor >> 1);

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic [DIST_W-1:0] rem_i;
    logic [DIST_W-1:0] den_i;
    logic [NW-1:0]     num_i;
    logic [NW-1:0]     quo_i;
    logic [DIST_W:0]   trial;
    logic              ge;

    if (k == 0) begin : g_first
      assign rem_i = '0;
      assign den_i = divisor;
      assign num_i = num0;
      assign quo_i = '0;
    end else begin : g_next
      assign rem_i = rem_q[k-1];
      assign den_i = den_q[k-1];
      assign num_i = num_q[k-1];
      assign quo_i = quo_q[k-1];
    end

    assign trial = {rem_i, num_i[NW-1]};
    assign ge    = (trial >= {1'b0, den_i});

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k] <= ge ? DIST_W'(trial - {1'b0, den_i}) : trial[DIST_W-1:0];
        den_q[k] <= den_i;
        num_q[k] <= {num_i[NW-2:0], 1'b0};
        quo_q[k] <= {quo_i[NW-2:0], ge};
      end
    end
  end

  assign quot = quo_q[NW-1];

endmodule
`default_nettype wire

[src/srpp_mul.sv]
// Four-stage sign-magnitude fixed-point multiplier with rounding and saturation.
`default_nettype none
module srpp_mul import srpp_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic en,
  input  wire fx_t  a,
  input  wire fx_t  b,
  output fx_t       p
);

  localparam int LO_W = 32;
  localparam logic [96:0] RND = 97'(1) << (FRAC_BITS - 1);

  typedef struct packed {
    logic zero;
    logic sat;
    logic neg;
  } mflag_t;

  logic [63:0]  p00_1;
  logic [62:0]  p01_1;
  logic [62:0]  p10_1;
  logic [61:0]  p11_1;
  mflag_t       fl_1;
  logic [63:0]  mid_2;
  logic [63:0]  p00_2;
  logic [61:0]  p11_2;
  mflag_t       fl_2;
  logic [96:0]  t_3;
  logic [61:0]  p11_3;
  mflag_t       fl_3;
  logic [126:0] full;
  logic [126:0] shifted;
  logic [MAG_W-1:0] res_mag;

  always_ff @(posedge clk) begin
    if (en) begin
      p00_1 <= a.mag[LO_W-1:0] * b.mag[LO_W-1:0];
      p01_1 <= a.mag[LO_W-1:0] * b.mag[MAG_W-1:LO_W];
      p10_1 <= a.mag[MAG_W-1:LO_W] * b.mag[LO_W-1:0];
      p11_1 <= a.mag[MAG_W-1:LO_W] * b.mag[MAG_W-1:LO_W];
      fl_1  <= '{zero: (a.mag == '0) || (b.mag == '0),
                 sat:  a.mag[MAG_W-1] || b.mag[MAG_W-1],
                 neg:  a.neg ^ b.neg};

      mid_2 <= {1'b0, p01_1} + {1'b0, p10_1};
      p00_2 <= p00_1;
      p11_2 <= p11_1;
      fl_2  <= fl_1;

      t_3   <= {mid_2, 32'b0} + {33'b0, p00_2} + RND;
      p11_3 <= p11_2;
      fl_3  <= fl_2;

      p     <= (fl_3.zero) ? '0 :
               (fl_3.sat)  ? fx_t'{neg: fl_3.neg, mag: MAG_CAP} :
                             fx_t'{neg: fl_3.neg && (res_mag != '0), mag: res_mag};
    end
  end

  assign full    = {1'b0, p11_3, 64'b0} + {30'b0, t_3};
  assign shifted = full >> FRAC_BITS;
  assign res_mag = (shifted >= 127'(MAG_CAP)) ? MAG_CAP : shifted[MAG_W-1:0];

endmodule
`default_nettype wire

[src/short_range_pair_potential_top.sv]
// Top level of the short-range pair potential: energy and force from one pair distance.
//
//  channel | handshake            | word
//  --------+----------------------+-------------------------------------
//  in      | in_valid / in_stall  | distance (Q8.16)
//  out     | out_valid / out_stall| energy, force_res (Q32.16), status
//  cfg     | cfg_write            | cfg_index, cfg_data
//
// One word per cycle enters while in_stall is low; the path runs through the
// 33-stage reciprocal divider at FRAC_BITS 16, five 4-stage multiply levels,
// three add stages, and the input and output registers.
// rst clears valid bits and the output valid, and loads the two config registers with their reset values.
// A two-word output register and skid hold results; the pipeline freezes only
// while the skid holds a word, and in_stall is high exactly then.
`default_nettype none
module short_range_pair_potential_top import srpp_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [DIST_W-1:0]        distance,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic signed [OUT_W-1:0]       energy,
  output logic signed [OUT_W-1:0]       force_res,
  output logic [1:0]                    status,
  input  wire logic                     cfg_write,
  input  wire logic [0:0]               cfg_index,
  input  wire logic [ALPHA_W-1:0]       cfg_data
);

  localparam int NW        = div_width(FRAC_BITS);
  localparam int FLAG_DLY  = NW + 5 * MUL_LAT + ADD_LAT;
  localparam int DE_DLY    = MUL_LAT + ADD_LAT + MUL_LAT;
  localparam fx_t MINUS_ONE = '{neg: 1'b1, mag: MAG_W'(1) << FRAC_BITS};

  logic [DIST_W-1:0]  cutoff_radius;
  logic [ALPHA_W-1:0] energy_scale;

  logic              en;
  logic              skid_full;
  logic [DIST_W-1:0] dist0;
  flags_t            fl0;
  flags_t            fl_fin;
  logic [NW-1:0]     quot;

  fx_t inv, cut, alpha;
  fx_t inv_sq, cut_sq, cut_sq_d, de_now, de_d;
  fx_t ratio, f1, f1_d;
  fx_t dr_a, s3_a, s2n_a, g1_b, dr_b, g_c, dr_c, g_d;
  fx_t drdr, f2, e1, f3, e_fin, f4, fo_fx;
  out_t eo, fo;
  res_t res_next;
  res_t out_word, skid_word;

  assign en       = !skid_full;
  assign in_stall = skid_full;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cutoff_radius <= 24'd131072;
      energy_scale  <= 32'd65536;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_CUTOFF: cutoff_radius <= cfg_data[DIST_W-1:0];
        REG_SCALE:  energy_scale  <= cfg_data;
        default:    ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      fl0 <= '0;
    end else if (en) begin
      fl0 <= '{vld: in_valid, zero: (distance == '0), beyond: (distance > cutoff_radius)};
    end
  end

  always_ff @(posedge clk) begin
    if (en) dist0 <= distance;
  end

  srpp_dly #(.WIDTH($bits(flags_t)), .DEPTH(FLAG_DLY)) u_flag_dly (
    .clk(clk), .rst(rst), .en(en), .din(fl0), .dout(fl_fin)
  );

  srpp_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk(clk), .en(en), .divisor(dist0), .quot(quot)
  );

  assign inv   = '{neg: 1'b0, mag: MAG_W'(quot)};
  assign cut   = '{neg: 1'b0, mag: MAG_W'(cutoff_radius)};
  assign alpha = '{neg: 1'b0, mag: MAG_W'(energy_scale)};

  // level 1: squares
  srpp_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_inv_sq (
    .clk(clk), .en(en), .a(inv), .b(inv), .p(inv_sq)
  );
  srpp_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_cut_sq (
    .clk(clk), .en(en), .a(cut), .b(cut), .p(cut_sq)
  );

  assign de_now = fx_add(inv_sq, MINUS_ONE);

  srpp_dly #(.WIDTH($bits(fx_t)), .DEPTH(DE_DLY)) u_de_dly (
    .clk(clk), .rst(rst), .en(en), .din(de_now), .dout(de_d)
  );
  srpp_dly #(.WIDTH($bits(fx_t)), .DEPTH(MUL_LAT)) u_cut_dly (
    .clk(clk), .rst(rst), .en(en), .din(cut_sq), .dout(cut_sq_d)
  );

  // level 2: ratio and 1/r^4
  srpp_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_ratio (
    .clk(clk), .en(en), .a(cut_sq_d), .b(inv_sq), .p(ratio)
  );
  srpp_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_f1 (
    .clk(clk), .en(en), .a(inv_sq), .b(inv_sq), .p(f1)
  );

  // add stages: dr = ratio - 1, g = 3*ratio - 2*cut_sq - 1
  always_ff @(posedge clk) begin
    if (en) begin
      dr_a  <= fx_add(ratio, MINUS_ONE);
      s3_a  <= fx_scale(ratio, 2'd3, SCALE3_LIM);
      s2n_a <= fx_make(1'b1, {1'b0, fx_scale(cut_sq_d, 2'd2, SCALE2_LIM).mag});
      g1_b  <= fx_add(s3_a, s2n_a);
      dr_b  <= dr_a;
      g_c   <= fx_add(g1_b, MINUS_ONE);
      dr_c  <= dr_b;
    end
  end

  srpp_dly #(.WIDTH($bits(fx_t)), .DEPTH(ADD_LAT)) u_f1_dly (
    .clk(clk), .rst(rst), .en(en), .din(f1), .dout(f1_d)
  );
  srpp_dly #(.WIDTH($bits(fx_t)), .DEPTH(MUL_LAT)) u_g_dly (
    .clk(clk), .rst(rst), .en(en), .din(g_c), .dout(g_d)
  );

  // level 3
  srpp_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_drdr (
    .clk(clk), .en(en), .a(dr_c), .b(dr_c), .p(drdr)
  );
  srpp_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_f2 (
    .clk(clk), .en(en), .a(f1_d), .b(dr_c), .p(f2)
  );

  // level 4
  srpp_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_e1 (
    .clk(clk), .en(en), .a(de_d), .b(drdr), .p(e1)
  );
  srpp_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_f3 (
    .clk(clk), .en(en), .a(f2), .b(g_d), .p(f3)
  );

  // level 5: prefactor
  srpp_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_en (
    .clk(clk), .en(en), .a(alpha), .b(e1), .p(e_fin)
  );
  srpp_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_f4 (
    .clk(clk), .en(en), .a(alpha), .b(f3), .p(f4)
  );

  // output formatting
  assign fo_fx = fx_scale(f4, 2'd2, SCALE2_LIM);
  assign eo    = fx_out(e_fin);
  assign fo    = fx_out(fo_fx);

  always_comb begin
    priority if (fl_fin.zero) begin
      res_next = '{energy: '0, force_res: '0, status: ST_ZERO};
    end else if (fl_fin.beyond) begin
      res_next = '{energy: '0, force_res: '0, status: ST_BEYOND};
    end else begin
      res_next.energy    = eo.val;
      res_next.force_res = fo.val;
      res_next.status    = (eo.sat || fo.sat) ? ST_SAT : ST_OK;
    end
  end

  // output register with one skid word
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_full <= 1'b0;
    end else if (skid_full) begin
      if (!out_valid || !out_stall) begin
        out_valid <= 1'b1;
        skid_full <= 1'b0;
      end
    end else if (fl_fin.vld) begin
      if (!out_valid || !out_stall) begin
        out_valid <= 1'b1;
      end else begin
        skid_full <= 1'b1;
      end
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_full) begin
      if (!out_valid || !out_stall) out_word <= skid_word;
    end else if (fl_fin.vld) begin
      if (!out_valid || !out_stall) out_word  <= res_next;
      else                          skid_word <= res_next;
    end
  end

  assign energy    = out_word.energy;
  assign force_res = out_word.force_res;
  assign status    = out_word.status;

endmodule
`default_nettype wire

[tb/short_range_pair_potential_top_tb.sv]
// Testbench for the short-range pair potential block: streams distances and checks each result.
`timescale 1ns / 1ps
module short_range_pair_potential_top_tb import srpp_pkg::*;;

  localparam int F = FRAC_BITS_DEF;
  localparam logic [63:0] CAP = 64'd1 << 62;
  localparam logic [63:0] ONE = 64'd1 << F;
  localparam int LIMIT = 400000;
  localparam int DRAIN = 80;

  typedef struct {
    bit          neg;
    logic [63:0] mag;
  } num_t;

  typedef struct {
    logic [OUT_W-1:0] energy;
    logic [OUT_W-1:0] force_res;
    status_t          status;
  } pair_res_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [DIST_W-1:0]  distance = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [OUT_W-1:0]   energy;
  logic [OUT_W-1:0]   force_res;
  logic [1:0]         status;
  logic               cfg_write = 1'b0;
  logic [0:0]         cfg_index = REG_CUTOFF;
  logic [ALPHA_W-1:0] cfg_data = '0;

  logic [DIST_W-1:0]  pending[$];
  pair_res_t          expected[$];
  logic [23:0]        cutoff_q = 24'd131072;
  logic [31:0]        alpha_q = 32'd65536;
  bit                 taken = 1'b0;
  bit                 hold = 1'b0;
  int                 cycle = 0;
  int                 errors = 0;

  short_range_pair_potential_top dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic num_t mk(bit n, logic [63:0] m);
    num_t r;
    r.mag = (m >= CAP) ? CAP : m;
    r.neg = (r.mag != 0) && n;
    return r;
  endfunction

  function automatic num_t mul(num_t a, num_t b);
    logic [127:0] p;
    bit           n;
    n = a.neg ^ b.neg;
    if (a.mag == 0 || b.mag == 0) return mk(0, 0);
    if (a.mag >= CAP || b.mag >= CAP) return mk(n, CAP);
    p = (128'(a.mag) * 128'(b.mag) + (128'd1 << (F - 1))) >> F;
    if (p >= 128'(CAP)) return mk(n, CAP);
    return mk(n, p[63:0]);
  endfunction

  function automatic num_t scale(num_t a, logic [63:0] k);
    if (a.mag >= CAP || a.mag > (CAP - 1) / k) return mk(a.neg, CAP);
    return mk(a.neg, a.mag * k);
  endfunction

  function automatic num_t add(num_t a, num_t b);
    if (a.mag >= CAP) return a;
    if (b.mag >= CAP) return b;
    if (a.neg == b.neg) return mk(a.neg, a.mag + b.mag);
    if (a.mag >= b.mag) return mk(a.neg, a.mag - b.mag);
    return mk(b.neg, b.mag - a.mag);
  endfunction

  function automatic logic [OUT_W-1:0] clamp_out(num_t v, inout bit sat);
    logic [63:0] m;
    m = v.mag;
    if (v.neg) begin
      if (m > 64'h8000_0000_0000) begin
        m = 64'h8000_0000_0000;
        sat = 1'b1;
      end
      return ~m[OUT_W-1:0] + 48'd1;
    end
    if (m > 64'h7FFF_FFFF_FFFF) begin
      m = 64'h7FFF_FFFF_FFFF;
      sat = 1'b1;
    end
    return m[OUT_W-1:0];
  endfunction

  function automatic pair_res_t pair_potential(logic [23:0] d);
    pair_res_t r;
    num_t      m1, inv, inv_sq, cut_sq, ratio, dr, de, en, g, fo;
    bit        sat;
    sat = 1'b0;
    r.energy = '0;
    r.force_res = '0;
    if (d == 0) begin
      r.status = ST_ZERO;
      return r;
    end
    if (d > cutoff_q) begin
      r.status = ST_BEYOND;
      return r;
    end
    m1 = mk(1, ONE);
    inv = mk(0, ((64'd1 << (2 * F)) + 64'(d) / 2) / 64'(d));
    inv_sq = mul(inv, inv);
    cut_sq = mul(mk(0, 64'(cutoff_q)), mk(0, 64'(cutoff_q)));
    ratio = mul(cut_sq, inv_sq);
    dr = add(ratio, m1);
    de = add(inv_sq, m1);
    en = mul(mk(0, 64'(alpha_q)), mul(de, mul(dr, dr)));
    g = add(scale(ratio, 3), mk(1, scale(cut_sq, 2).mag));
    g = add(g, m1);
    fo = mul(mul(mul(inv_sq, inv_sq), dr), g);
    fo = scale(mul(mk(0, 64'(alpha_q)), fo), 2);
    r.energy = clamp_out(en, sat);
    r.force_res = clamp_out(fo, sat);
    r.status = sat ? ST_SAT : ST_OK;
    return r;
  endfunction

  task automatic report(string what, logic [OUT_W-1:0] got, logic [OUT_W-1:0] want);
    $display("mismatch %s at cycle %0d: got %h want %h", what, cycle, got, want);
    errors++;
  endtask

  // Quiet window: no idling on either side.
  function automatic bit idle_now();
    if (cycle > 400 && cycle < 1100) return 1'b0;
    return $urandom_range(0, 99) < 12;
  endfunction

  // Drive: advance to the next word once the current one was taken.
  always @(negedge clk) begin
    if (!rst && (!in_valid || taken)) begin
      if (pending.size() > 0 && !hold && !idle_now()) begin
        distance <= pending.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_stall <= rst ? 1'b0 : idle_now();
  end

  always @(posedge clk) begin
    pair_res_t want;
    cycle <= cycle + 1;
    taken <= in_valid && !in_stall && !rst;
    if (!rst && in_valid && !in_stall) expected.push_back(pair_potential(distance));
    if (!rst && out_valid && !out_stall) begin
      if (expected.size() == 0) begin
        report("unexpected word", energy, '0);
      end else begin
        want = expected.pop_front();
        if (energy !== want.energy) report("energy", energy, want.energy);
        if (force_res !== want.force_res) report("force_res", force_res, want.force_res);
        if (status !== want.status) report("status", 48'(status), 48'(want.status));
      end
    end
    if (cycle > LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic write_reg(reg_index_t idx, logic [31:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    if (idx == REG_CUTOFF) cutoff_q = val[23:0];
    else alpha_q = val;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic drain();
    while (pending.size() > 0 || in_valid || expected.size() > 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  function automatic logic [23:0] rand_dist();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 60 && cutoff_q > 1) return 24'($urandom_range(1, cutoff_q));
    if (sel < 75) return 24'($urandom_range(0, 600));
    return 24'($urandom);
  endfunction

  task automatic load_random(int n);
    repeat (n) pending.push_back(rand_dist());
  endtask

  initial begin
    logic [23:0] edge_d[] = '{24'd0, 24'd1, 24'd2, 24'hFF_FFFF, 24'h02_0000, 24'h02_0001,
                              24'h01_0000, 24'h00_8000, 24'h00_0100, 24'h00_FFFF,
                              24'h01_FFFF, 24'h80_0000, 24'h55_5555, 24'hAA_AAAA};
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // Reset setting first.
    foreach (edge_d[i]) pending.push_back(edge_d[i]);
    load_random(200);
    drain();
    write_reg(REG_CUTOFF, 32'hFF_FFFF);
    write_reg(REG_SCALE, 32'hFFFF_FFFF);
    pending.push_back(24'd1);
    pending.push_back(24'hFF_FFFF);
    pending.push_back(24'd0);
    load_random(200);
    // Let words flow for a while, then hold off the sender until the pipe is empty.
    repeat (150) @(posedge clk);
    hold = 1'b1;
    while (in_valid || expected.size() > 0) @(posedge clk);
    hold = 1'b0;
    drain();
    write_reg(REG_CUTOFF, 32'd0);
    write_reg(REG_SCALE, 32'd0);
    load_random(60);
    drain();
    write_reg(REG_CUTOFF, 32'h01_8000);
    load_random(200);
    drain();
    repeat (3) begin
      write_reg(REG_CUTOFF, $urandom & 32'hFF_FFFF);
      write_reg(REG_SCALE, $urandom);
      load_random(180);
      drain();
    end
    if (errors == 0 && expected.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
